FILE: design/amgc_pkg.sv
// amgc_pkg: shared types and constants for the adc median gain calibrator
// used by amgc_ctrl, amgc_dp and adc_median_gain_calibrator_unit; no dependencies
package amgc_pkg;

	localparam int CFG_W    = 6;
	localparam int SAMPLE_W = 12;
	localparam int MV_W     = 16;
	localparam int STATUS_W = 2;
	localparam int MED_W    = 13;
	localparam int GAIN_W   = 19;
	localparam int STORED_W = 18;
	localparam int PROD_W   = 32;
	localparam int DIV_CNT_W = 5;

	localparam int IN_TDATA_W  = 32;
	localparam int OUT_TDATA_W = 56;

	localparam logic [CFG_W-1:0]    SAMPLE_COUNT_RST = 6'd16;
	localparam logic [MV_W-1:0]     MV_LOW      = 16'd11000;
	localparam logic [MV_W-1:0]     MV_HIGH     = 16'd16000;
	localparam logic [GAIN_W-1:0]   GAIN_LOW    = 19'd160000;
	localparam logic [GAIN_W-1:0]   GAIN_HIGH   = 19'd230000;
	localparam logic [STORED_W-1:0] GAIN_RST    = 18'd195700;
	localparam logic [PROD_W-1:0]   GAIN_SCALE  = 32'd500000;
	localparam logic [PROD_W-1:0]   NEW_GAIN_MAX = 32'd524287;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK   = 2'd0,
		ST_VOLT = 2'd1,
		ST_GAIN = 2'd2,
		ST_FEW  = 2'd3
	} status_t;

	typedef enum logic {
		ACT_LOAD    = 1'b0,
		ACT_COMPUTE = 1'b1
	} action_t;

	typedef struct packed {
		logic load;
		logic start;
		logic cand_latch;
		logic sweep;
		logic rank;
		logic med;
		logic mul;
		logic div_step;
		logic finish;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic pre_fail;
		logic out_free;
	} stat_t;

endpackage

FILE: design/adc_median_gain_calibrator_unit.sv
// adc median gain calibrator: input stream of load/compute words, one result
// word per compute; the block writes ADC readings into an internal memory.
// s_axis: tuser = action (0 load sample, 1 compute gain); tdata see port list.
// m_axis: one word per compute with status, twice-median, new and stored gain.
// cfg: write of sample_count, taken in any cycle (cfg_ready is always high).
// a load is taken while idle and the next word may follow at once.
// a compute rejected for voltage or sample count skips ranking and goes
// through the done state to the output register. a full compute ranks n
// readings by sweeping the memory once per candidate through its single
// read port, then adds the two middle values, multiplies, runs the
// bit-serial divider, checks the gain and registers the result.
// one compute is in flight at a time; s_axis_tready is low meanwhile.
// reset clears the load count, restores sample_count 16 and gain 195700.
// when the receiver stalls the result word holds in its output register and
// further loads are still taken; a following compute waits before its output.
// depends on amgc_pkg, amgc_ctrl and amgc_dp
module adc_median_gain_calibrator_unit #(
	parameter int MAX_SAMPLES = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// [11:0] adc_sample, [27:12] battery_mv, [31:28] zero
	input  logic [amgc_pkg::IN_TDATA_W-1:0] s_axis_tdata,
	// [0] action
	input  logic s_axis_tuser,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// [1:0] status, [14:2] median_twice, [33:15] new_gain_milli,
	// [51:34] stored_gain_milli, [55:52] zero
	output logic [amgc_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [amgc_pkg::CFG_W-1:0] cfg_data
);

	localparam int AW = $clog2(MAX_SAMPLES);
	localparam int CW = $clog2(MAX_SAMPLES + 1);

	amgc_pkg::cmd_t  cmd;
	amgc_pkg::stat_t stat;
	logic [AW-1:0]   rd_addr;
	logic [CW-1:0]   n_eff;

	assign cfg_ready = 1'b1;

	amgc_ctrl #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.action   (s_axis_tuser),
		.stat     (stat),
		.n_eff    (n_eff),
		.s_tready (s_axis_tready),
		.cmd      (cmd),
		.rd_addr  (rd_addr)
	);

	amgc_dp #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.rd_addr   (rd_addr),
		.sample    (s_axis_tdata[amgc_pkg::SAMPLE_W-1:0]),
		.mv        (s_axis_tdata[amgc_pkg::SAMPLE_W +: amgc_pkg::MV_W]),
		.cfg_valid (cfg_valid),
		.cfg_data  (cfg_data),
		.m_tready  (m_axis_tready),
		.n_eff     (n_eff),
		.stat      (stat),
		.m_tvalid  (m_axis_tvalid),
		.m_tdata   (m_axis_tdata)
	);

endmodule

FILE: design/amgc_ctrl.sv
// amgc_ctrl: sequencer for the calibrator (accept, rank sweeps, divide, output)
// depends on amgc_pkg; drives amgc_dp through cmd_t and reads stat_t
module amgc_ctrl #(
	parameter int MAX_SAMPLES = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	input  logic action,
	input  amgc_pkg::stat_t stat,
	input  logic [$clog2(MAX_SAMPLES+1)-1:0] n_eff,
	output logic s_tready,
	output amgc_pkg::cmd_t cmd,
	output logic [$clog2(MAX_SAMPLES)-1:0] rd_addr
);

	localparam int AW = $clog2(MAX_SAMPLES);

	typedef enum logic [3:0] {
		S_IDLE, S_CAND_RD, S_CAND_LATCH, S_SWEEP, S_RANK,
		S_MED, S_MUL, S_DIV, S_CHECK, S_DONE
	} state_t;

	state_t state_q;
	logic [AW-1:0] i_q;
	logic [AW-1:0] j_q;
	logic [amgc_pkg::DIV_CNT_W-1:0] div_cnt_q;
	logic [AW-1:0] last;
	logic acc;

	assign last     = AW'(n_eff - 1'b1);
	assign s_tready = (state_q == S_IDLE);
	assign acc      = (state_q == S_IDLE) && s_tvalid;

	always_comb begin
		cmd            = '0;
		rd_addr        = '0;
		cmd.load       = acc && (action == amgc_pkg::ACT_LOAD);
		cmd.start      = acc && (action == amgc_pkg::ACT_COMPUTE);
		case (state_q)
			S_CAND_RD: begin
				rd_addr = i_q;
			end
			S_CAND_LATCH: begin
				cmd.cand_latch = 1'b1;
			end
			S_SWEEP: begin
				cmd.sweep = 1'b1;
				rd_addr   = j_q + 1'b1;
			end
			S_RANK:  cmd.rank = 1'b1;
			S_MED:   cmd.med = 1'b1;
			S_MUL:   cmd.mul = 1'b1;
			S_DIV:   cmd.div_step = 1'b1;
			S_CHECK: cmd.finish = 1'b1;
			S_DONE:  cmd.out_load = stat.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			i_q       <= '0;
			j_q       <= '0;
			div_cnt_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (acc && (action == amgc_pkg::ACT_COMPUTE)) begin
						i_q     <= '0;
						state_q <= stat.pre_fail ? S_DONE : S_CAND_RD;
					end
				end
				S_CAND_RD: state_q <= S_CAND_LATCH;
				S_CAND_LATCH: begin
					j_q     <= '0;
					state_q <= S_SWEEP;
				end
				S_SWEEP: begin
					if (j_q == last) begin
						state_q <= S_RANK;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				S_RANK: begin
					if (i_q == last) begin
						state_q <= S_MED;
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= S_CAND_RD;
					end
				end
				S_MED: state_q <= S_MUL;
				S_MUL: begin
					div_cnt_q <= '0;
					state_q   <= S_DIV;
				end
				S_DIV: begin
					div_cnt_q <= div_cnt_q + 1'b1;
					if (div_cnt_q == '1) begin
						state_q <= S_CHECK;
					end
				end
				S_CHECK: state_q <= S_DONE;
				S_DONE: begin
					if (stat.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

FILE: design/amgc_dp.sv
// amgc_dp: datapath with sample memory, rank counters, multiplier, divider
// and result register; depends on amgc_pkg, commanded by amgc_ctrl
module amgc_dp #(
	parameter int MAX_SAMPLES = 32
) (
	input  logic clk,
	input  logic arst_n,
	input  amgc_pkg::cmd_t cmd,
	input  logic [$clog2(MAX_SAMPLES)-1:0] rd_addr,
	input  logic [amgc_pkg::SAMPLE_W-1:0] sample,
	input  logic [amgc_pkg::MV_W-1:0] mv,
	input  logic cfg_valid,
	input  logic [amgc_pkg::CFG_W-1:0] cfg_data,
	input  logic m_tready,
	output logic [$clog2(MAX_SAMPLES+1)-1:0] n_eff,
	output amgc_pkg::stat_t stat,
	output logic m_tvalid,
	output logic [amgc_pkg::OUT_TDATA_W-1:0] m_tdata
);

	localparam int AW = $clog2(MAX_SAMPLES);
	localparam int CW = $clog2(MAX_SAMPLES + 1);
	localparam int XW = (CW > amgc_pkg::CFG_W) ? CW : amgc_pkg::CFG_W;
	localparam int PAD_W = amgc_pkg::OUT_TDATA_W - amgc_pkg::STATUS_W - amgc_pkg::MED_W
		- amgc_pkg::GAIN_W - amgc_pkg::STORED_W;

	logic [amgc_pkg::SAMPLE_W-1:0] mem [MAX_SAMPLES];
	logic [amgc_pkg::SAMPLE_W-1:0] rd_q;

	logic [amgc_pkg::CFG_W-1:0]    sample_count_q;
	logic [CW-1:0]                 loaded_q;
	logic [amgc_pkg::MV_W-1:0]     mv_q;
	amgc_pkg::status_t             status_q;
	logic [amgc_pkg::SAMPLE_W-1:0] cand_q;
	logic [CW-1:0]                 lt_q;
	logic [CW-1:0]                 le_q;
	logic [amgc_pkg::SAMPLE_W-1:0] v1_q;
	logic [amgc_pkg::SAMPLE_W-1:0] v2_q;
	logic [amgc_pkg::MED_W-1:0]    med_q;
	logic [amgc_pkg::PROD_W-1:0]   quo_q;
	logic [amgc_pkg::MV_W-1:0]     rem_q;
	logic [amgc_pkg::GAIN_W-1:0]   gain_q;
	logic [amgc_pkg::STORED_W-1:0] stored_q;
	logic                          m_tvalid_q;
	logic [amgc_pkg::OUT_TDATA_W-1:0] m_tdata_q;

	logic [XW-1:0] sc_x;
	logic [CW-1:0] k1, k2;
	logic          vfail, ffail;
	logic [amgc_pkg::MV_W:0] trial;
	logic          trial_ok;
	logic [amgc_pkg::GAIN_W-1:0] gain_sat;

	assign sc_x = XW'(sample_count_q);

	always_comb begin
		if (sample_count_q == '0) begin
			n_eff = CW'(1);
		end else if (sc_x > XW'(MAX_SAMPLES)) begin
			n_eff = CW'(MAX_SAMPLES);
		end else begin
			n_eff = CW'(sc_x);
		end
	end

	assign k1 = (n_eff - 1'b1) >> 1;
	assign k2 = n_eff >> 1;

	assign vfail = (mv < amgc_pkg::MV_LOW) || (mv > amgc_pkg::MV_HIGH);
	assign ffail = (loaded_q < n_eff);

	always_comb begin
		stat.pre_fail = vfail || ffail;
		stat.out_free = !m_tvalid_q || m_tready;
	end

	assign trial    = {rem_q, quo_q[amgc_pkg::PROD_W-1]};
	assign trial_ok = (trial >= {1'b0, mv_q});
	assign gain_sat = (quo_q > amgc_pkg::NEW_GAIN_MAX) ? amgc_pkg::NEW_GAIN_MAX[amgc_pkg::GAIN_W-1:0]
		: quo_q[amgc_pkg::GAIN_W-1:0];

	// sample memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.load && (loaded_q < CW'(MAX_SAMPLES))) begin
			mem[loaded_q[AW-1:0]] <= sample;
		end
		rd_q <= mem[rd_addr];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			mv_q <= mv;
		end
		if (cmd.cand_latch) begin
			cand_q <= rd_q;
			lt_q   <= '0;
			le_q   <= '0;
		end
		if (cmd.sweep) begin
			if (rd_q < cand_q) begin
				lt_q <= lt_q + 1'b1;
			end
			if (rd_q <= cand_q) begin
				le_q <= le_q + 1'b1;
			end
		end
		if (cmd.rank) begin
			if ((lt_q <= k1) && (k1 < le_q)) begin
				v1_q <= cand_q;
			end
			if ((lt_q <= k2) && (k2 < le_q)) begin
				v2_q <= cand_q;
			end
		end
		if (cmd.mul) begin
			quo_q <= amgc_pkg::PROD_W'(med_q) * amgc_pkg::GAIN_SCALE;
			rem_q <= '0;
		end
		if (cmd.div_step) begin
			quo_q <= {quo_q[amgc_pkg::PROD_W-2:0], trial_ok};
			rem_q <= trial_ok ? amgc_pkg::MV_W'(trial - {1'b0, mv_q})
				: trial[amgc_pkg::MV_W-1:0];
		end
		if (cmd.out_load) begin
			m_tdata_q <= {PAD_W'(0), stored_q, gain_q, med_q, status_q};
		end
	end

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_count_q <= amgc_pkg::SAMPLE_COUNT_RST;
			loaded_q       <= '0;
			stored_q       <= amgc_pkg::GAIN_RST;
			status_q       <= amgc_pkg::ST_OK;
			med_q          <= '0;
			gain_q         <= '0;
			m_tvalid_q     <= 1'b0;
		end else begin
			if (cfg_valid) begin
				sample_count_q <= cfg_data;
			end
			if (cmd.load && (loaded_q < CW'(MAX_SAMPLES))) begin
				loaded_q <= loaded_q + 1'b1;
			end
			if (cmd.start) begin
				med_q  <= '0;
				gain_q <= '0;
				if (vfail) begin
					status_q <= amgc_pkg::ST_VOLT;
				end else if (ffail) begin
					status_q <= amgc_pkg::ST_FEW;
				end else begin
					status_q <= amgc_pkg::ST_OK;
				end
			end
			if (cmd.med) begin
				med_q <= {1'b0, v1_q} + {1'b0, v2_q};
			end
			if (cmd.finish) begin
				gain_q <= gain_sat;
				if ((gain_sat < amgc_pkg::GAIN_LOW) || (gain_sat > amgc_pkg::GAIN_HIGH)) begin
					status_q <= amgc_pkg::ST_GAIN;
				end else begin
					stored_q <= gain_sat[amgc_pkg::STORED_W-1:0];
				end
			end
			if (cmd.out_load) begin
				loaded_q   <= '0;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

FILE: tb/tb_top.sv
// tb_top: self-checking bench for adc_median_gain_calibrator_unit, predicting each
// compute result from its own copy of the sample store, load count, gain and sample_count
// depends on amgc_pkg and the design files of adc_median_gain_calibrator_unit
module tb_top;

	localparam int STORE_DEPTH = 32;

	typedef struct {
		amgc_pkg::action_t act;
		logic [11:0]   smp;
		logic [15:0]   mv;
	} in_word_t;

	typedef struct {
		amgc_pkg::status_t status;
		logic [12:0]   med2;
		logic [18:0]   new_gain;
		logic [17:0]   stored;
	} calib_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [amgc_pkg::IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [amgc_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [amgc_pkg::CFG_W-1:0] cfg_data = '0;

	in_word_t pending_words[$];
	calib_result_t expected_calib[$];

	logic [11:0] store_model [STORE_DEPTH];
	int unsigned loaded_model = 0;
	logic [17:0] gain_model = amgc_pkg::GAIN_RST;
	logic [5:0] count_cfg = amgc_pkg::SAMPLE_COUNT_RST;

	bit in_taken = 1'b0;
	bit cfg_taken = 1'b0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int fail_count = 0;
	int phase_items = 0;

	adc_median_gain_calibrator_unit #(
		.MAX_SAMPLES(STORE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#100_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

	function automatic int unsigned effective_count(input logic [5:0] cnt);
		if (cnt == 0) begin
			return 1;
		end
		if (cnt > STORE_DEPTH) begin
			return STORE_DEPTH;
		end
		return cnt;
	endfunction

	task automatic predict_calibration(input amgc_pkg::action_t act, input logic [11:0] smp,
			input logic [15:0] mv);
		logic [11:0] ranked [STORE_DEPTH];
		logic [11:0] v;
		int unsigned n;
		int i;
		int j;
		longint unsigned g;
		calib_result_t r;
		r.status = amgc_pkg::ST_OK;
		r.med2 = '0;
		r.new_gain = '0;
		n = effective_count(count_cfg);
		if (act == amgc_pkg::ACT_LOAD) begin
			if (loaded_model < STORE_DEPTH) begin
				store_model[loaded_model] = smp;
				loaded_model++;
			end
			return;
		end
		if (mv < amgc_pkg::MV_LOW || mv > amgc_pkg::MV_HIGH) begin
			r.status = amgc_pkg::ST_VOLT;
		end else if (loaded_model < n) begin
			r.status = amgc_pkg::ST_FEW;
		end else begin
			for (i = 0; i < n; i++) begin
				ranked[i] = store_model[i];
			end
			for (i = 1; i < n; i++) begin
				v = ranked[i];
				j = i;
				while (j > 0 && ranked[j-1] > v) begin
					ranked[j] = ranked[j-1];
					j--;
				end
				ranked[j] = v;
			end
			if (n % 2 == 0) begin
				r.med2 = {1'b0, ranked[n/2-1]} + {1'b0, ranked[n/2]};
			end else begin
				r.med2 = {ranked[n/2], 1'b0};
			end
			g = longint'(r.med2) * 500000 / longint'(mv);
			if (g > amgc_pkg::NEW_GAIN_MAX) begin
				g = amgc_pkg::NEW_GAIN_MAX;
			end
			r.new_gain = g[18:0];
			if (r.new_gain < amgc_pkg::GAIN_LOW || r.new_gain > amgc_pkg::GAIN_HIGH) begin
				r.status = amgc_pkg::ST_GAIN;
			end else begin
				gain_model = r.new_gain[17:0];
			end
		end
		loaded_model = 0;
		r.stored = gain_model;
		expected_calib.insert(expected_calib.size(), r);
	endtask

	task automatic report_failure(input string msg);
		fail_count++;
		if (fail_count <= 10) begin
			$display("%0t: %s", $realtime, msg);
		end
	endtask

	// monitor and checker
	always @(posedge clk) begin
		calib_result_t got;
		calib_result_t want;
		in_taken = arst_n && s_axis_tvalid && s_axis_tready;
		cfg_taken = arst_n && cfg_valid && cfg_ready;
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.status = amgc_pkg::status_t'(m_axis_tdata[1:0]);
				got.med2 = m_axis_tdata[14:2];
				got.new_gain = m_axis_tdata[33:15];
				got.stored = m_axis_tdata[51:34];
				if (expected_calib.size() == 0) begin
					report_failure($sformatf("result word with none expected: %h",
						m_axis_tdata));
				end else begin
					want = expected_calib[0];
					expected_calib.delete(0);
					if (got.status != want.status || got.med2 != want.med2 ||
							got.new_gain != want.new_gain || got.stored != want.stored) begin
						report_failure({
							$sformatf("mismatch exp st %0d med2 %0d gain %0d stored %0d",
								want.status, want.med2, want.new_gain, want.stored),
							$sformatf(", got st %0d med2 %0d gain %0d stored %0d",
								got.status, got.med2, got.new_gain, got.stored)});
					end
				end
			end
			if (cfg_taken) begin
				count_cfg = cfg_data;
			end
			if (in_taken) begin
				predict_calibration(amgc_pkg::action_t'(s_axis_tuser), s_axis_tdata[11:0],
					s_axis_tdata[27:12]);
			end
		end
	end

	// driver
	always @(negedge clk) begin
		in_word_t w;
		if (arst_n && (!s_axis_tvalid || in_taken)) begin
			if (pending_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				w = pending_words[0];
				pending_words.delete(0);
				s_axis_tvalid <= 1'b1;
				s_axis_tuser <= w.act;
				s_axis_tdata <= {4'b0000, w.mv, w.smp};
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	task automatic push_word(input amgc_pkg::action_t act, input logic [11:0] smp,
			input logic [15:0] mv);
		in_word_t w;
		w.act = act;
		w.smp = smp;
		w.mv = mv;
		pending_words.insert(pending_words.size(), w);
		phase_items++;
	endtask

	task automatic wait_drained();
		do begin
			@(posedge clk);
		end while (pending_words.size() != 0 || s_axis_tvalid || expected_calib.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_sample_count(input logic [5:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do begin
			@(negedge clk);
		end while (!cfg_taken);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [15:0] edge_voltage();
		case ($urandom_range(0, 5))
			0: return 16'd10999;
			1: return 16'd11000;
			2: return 16'd16000;
			3: return 16'd16001;
			4: return 16'd0;
			default: return 16'd65535;
		endcase
	endfunction

	// loads around a median that lands near the gain window, then one compute
	task automatic push_calibration_run(input int unsigned n_eff);
		logic [15:0] mv;
		longint target;
		int base;
		int spread;
		int k;
		int s;
		int sel;
		int i;
		mv = $urandom_range(11000, 16000);
		target = $urandom_range(150000, 240000);
		base = int'(target * mv / 500000) / 2;
		spread = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 400);
		sel = $urandom_range(0, 9);
		k = n_eff;
		if (sel == 0) begin
			k = n_eff + $urandom_range(1, 6);
		end else if (sel == 1) begin
			k = $urandom_range(0, n_eff - 1);
		end
		for (i = 0; i < k; i++) begin
			s = base - spread + $urandom_range(0, 2 * spread);
			if (s < 0) begin
				s = 0;
			end
			if (s > 4095) begin
				s = 4095;
			end
			push_word(amgc_pkg::ACT_LOAD, s[11:0], 16'($urandom));
		end
		if (sel == 2) begin
			mv = edge_voltage();
		end
		push_word(amgc_pkg::ACT_COMPUTE, 12'($urandom), mv);
	endtask

	task automatic push_noise();
		logic [11:0] smp;
		smp = $urandom_range(0, 4095);
		if ($urandom_range(0, 9) == 0) begin
			smp = ($urandom_range(0, 1) == 0) ? 12'd0 : 12'd4095;
		end
		if ($urandom_range(0, 99) < 25) begin
			push_word(amgc_pkg::ACT_COMPUTE, smp,
				($urandom_range(0, 1) == 0) ? edge_voltage() : 16'($urandom));
		end else begin
			push_word(amgc_pkg::ACT_LOAD, smp, 16'($urandom));
		end
	endtask

	initial begin
		logic [5:0] settings [12];
		int p;
		settings = '{6'd63, 6'd3, 6'd32, 6'd0, 6'd1, 6'd17,
			6'd8, 6'd33, 6'd2, 6'd16, 6'd5, 6'd31};
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// effective count of one
		write_sample_count(6'd0);
		push_word(amgc_pkg::ACT_COMPUTE, 12'd0, 16'd0);
		push_word(amgc_pkg::ACT_COMPUTE, 12'd4095, 16'd65535);
		push_word(amgc_pkg::ACT_COMPUTE, 12'd0, 16'd11000);
		push_word(amgc_pkg::ACT_LOAD, 12'd4095, 16'd0);
		push_word(amgc_pkg::ACT_COMPUTE, 12'd0, 16'd10999);
		push_word(amgc_pkg::ACT_LOAD, 12'd4095, 16'd65535);
		push_word(amgc_pkg::ACT_COMPUTE, 12'd0, 16'd11000);
		push_word(amgc_pkg::ACT_LOAD, 12'd0, 16'd0);
		push_word(amgc_pkg::ACT_COMPUTE, 12'd0, 16'd16000);
		push_word(amgc_pkg::ACT_LOAD, 12'd2400, 16'd0);
		push_word(amgc_pkg::ACT_COMPUTE, 12'd0, 16'd12000);
		push_word(amgc_pkg::ACT_LOAD, 12'd2400, 16'd0);
		push_word(amgc_pkg::ACT_LOAD, 12'd0, 16'd0);
		push_word(amgc_pkg::ACT_COMPUTE, 12'd0, 16'd16001);
		wait_drained();
		// even count
		write_sample_count(6'd2);
		push_word(amgc_pkg::ACT_LOAD, 12'd2000, 16'd0);
		push_word(amgc_pkg::ACT_LOAD, 12'd3000, 16'd0);
		push_word(amgc_pkg::ACT_COMPUTE, 12'd0, 16'd12000);
		push_word(amgc_pkg::ACT_LOAD, 12'd2500, 16'd0);
		push_word(amgc_pkg::ACT_COMPUTE, 12'd0, 16'd12500);
		wait_drained();

		for (p = 0; p < 12; p++) begin
			write_sample_count(settings[p]);
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 86;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 86;
				end
				default: begin
					send_idle_pct = 14;
					recv_stall_pct = 14;
				end
			endcase
			phase_items = 0;
			while (phase_items < 115) begin
				if ($urandom_range(0, 99) < 80) begin
					push_calibration_run(effective_count(settings[p]));
				end else begin
					push_noise();
				end
			end
			wait_drained();
		end

		repeat (50) @(posedge clk);
		if (expected_calib.size() != 0) begin
			report_failure("results still expected at end of run");
		end
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
